// ===== rtl/ahcp_pkg.sv =====
// Shared types, constants and helpers for the artificial horizon character placer.
package ahcp_pkg;

  localparam int ROLL_W    = 12;
  localparam int PITCH_W   = 11;
  localparam int Y_W       = 8;
  localparam int YPOS_W    = 7;
  localparam int COL_W     = 5;
  localparam int ROW_W     = 5;
  localparam int CODE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 5;
  localparam int LANE_W    = 4;
  localparam int SIDE_W    = 4;

  localparam int ROLL_LIM   = 400;
  localparam int PITCH_LIM  = 200;
  localparam int PITCH_DIV  = 8;
  localparam int P_OFFSET   = 41;
  localparam int ROLL_SHIFT = 6;
  localparam int Y_MAX      = 81;

  localparam int NUM_LANES   = 9;
  localparam int CENTER_LANE = 4;
  localparam int LAST_STEP   = 24;
  localparam int SIDE_DECO_N = 14;

  localparam int BAR_COL0        = 10;
  localparam int BAR_ROW0        = 2;
  localparam int SIDE_ROW0       = 3;
  localparam int CENTER_ROW      = 6;
  localparam int LEFT_DECO_COL   = 7;
  localparam int RIGHT_DECO_COL  = 21;
  localparam int LEFT_LEVEL_COL  = 8;
  localparam int RIGHT_LEVEL_COL = 20;
  localparam int ROW_MAX         = 12;

  localparam int DIV9_MUL   = 57;
  localparam int DIV9_SHIFT = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAL_MODE    = 3'd0,
    REG_SIDEBARS    = 3'd1,
    REG_BAR_BASE    = 3'd2,
    REG_DECO_SYM    = 3'd3,
    REG_LEFT_LEVEL  = 3'd4,
    REG_RIGHT_LEVEL = 3'd5
  } cfg_reg_t;

  typedef logic [YPOS_W-1:0] ypos_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] hit;
    ypos_t [NUM_LANES-1:0] ypos;
  } bar_set_t;

  typedef struct packed {
    logic              pal_mode;
    logic              sidebars_enable;
    logic [CODE_W-1:0] bar_symbol_base;
    logic [CODE_W-1:0] decoration_symbol;
    logic [CODE_W-1:0] left_level_symbol;
    logic [CODE_W-1:0] right_level_symbol;
  } cfg_t;

  typedef struct packed {
    logic              last;
    logic [CODE_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
  } res_t;

  // y / 9 for 0 <= y <= 81 by reciprocal multiply
  function automatic logic [3:0] div9(input ypos_t y);
    logic [15:0] prod;
    prod = 16'(y) * 16'(DIV9_MUL);
    return 4'(prod >> DIV9_SHIFT);
  endfunction

endpackage

// ===== rtl/ahcp_front.sv =====
// Angle clamp and per-column bar offset computation for all nine bar columns.
module ahcp_front import ahcp_pkg::*; (
  input  logic signed [ROLL_W-1:0]  roll_angle,
  input  logic signed [PITCH_W-1:0] pitch_angle,
  output bar_set_t                  bars
);

  logic signed [ROLL_W-1:0]  roll_c;
  logic signed [PITCH_W-1:0] pitch_c;
  logic signed [PITCH_W-1:0] pitch_q;
  logic                      roll_neg;
  logic [8:0]                roll_mag;
  logic signed [Y_W-1:0]     neg_p;

  always_comb begin
    if (roll_angle > ROLL_LIM) begin
      roll_c = ROLL_W'(ROLL_LIM);
    end else if (roll_angle < -ROLL_LIM) begin
      roll_c = ROLL_W'(-ROLL_LIM);
    end else begin
      roll_c = roll_angle;
    end
    if (pitch_angle > PITCH_LIM) begin
      pitch_c = PITCH_W'(PITCH_LIM);
    end else if (pitch_angle < -PITCH_LIM) begin
      pitch_c = PITCH_W'(-PITCH_LIM);
    end else begin
      pitch_c = pitch_angle;
    end
  end

  assign roll_neg = roll_c[ROLL_W-1];
  assign roll_mag = roll_neg ? 9'(-roll_c) : 9'(roll_c);
  // truncates toward zero
  assign pitch_q  = PITCH_W'(pitch_c / PITCH_DIV);
  assign neg_p    = Y_W'(P_OFFSET) - Y_W'(pitch_q);

  always_comb begin
    int                    k;
    logic [10:0]           prod;
    logic signed [Y_W-1:0] qm;
    logic signed [Y_W-1:0] y;
    for (int s = 0; s < NUM_LANES; s++) begin
      k    = (s < CENTER_LANE) ? CENTER_LANE - s : s - CENTER_LANE;
      prod = 11'(roll_mag * k);
      qm   = Y_W'(prod >> ROLL_SHIFT);
      // magnitude-based divide keeps C truncation
      if (roll_neg ^ (s > CENTER_LANE)) begin
        y = neg_p - qm;
      end else begin
        y = neg_p + qm;
      end
      bars.hit[s]  = (y >= 0) && (y <= Y_MAX);
      bars.ypos[s] = y[YPOS_W-1:0];
    end
  end

endmodule

// ===== rtl/ahcp_seq.sv =====
// Item register, write sequencer and result register.
module ahcp_seq import ahcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  bar_set_t bars_in,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     res
);

  bar_set_t          bars;
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [LANE_W-1:0] lane;
  logic [SIDE_W-1:0] side_idx;
  logic [NUM_LANES-1:0] later_mask;
  logic [3:0]        q9;
  logic [3:0]        r9;
  ypos_t             ysel;
  res_t              cand;
  logic              cand_ok;
  logic              out_free;
  logic              done;
  logic              advance;
  logic              emit;

  always_comb begin
    lane     = step[LANE_W-1:0];
    side_idx = SIDE_W'(step - STEP_W'(NUM_LANES));
    ysel     = bars.ypos[lane];
    q9       = div9(ysel);
    r9       = 4'(ysel - (YPOS_W'(q9) * YPOS_W'(9)));
    for (int i = 0; i < NUM_LANES; i++) begin
      later_mask[i] = (i > lane);
    end
    cand    = '0;
    cand_ok = 1'b0;
    if (step < STEP_W'(NUM_LANES)) begin
      cand_ok        = bars.hit[lane];
      cand.column    = COL_W'(BAR_COL0) + COL_W'(lane);
      cand.row       = ROW_W'(BAR_ROW0) + ROW_W'(cfg.pal_mode) + ROW_W'(q9);
      cand.char_code = cfg.bar_symbol_base + CODE_W'(r9);
      cand.last      = !cfg.sidebars_enable && !(|(bars.hit & later_mask));
    end else begin
      cand_ok = cfg.sidebars_enable;
      if (side_idx < SIDE_W'(SIDE_DECO_N)) begin
        cand.column    = side_idx[0] ? COL_W'(RIGHT_DECO_COL) : COL_W'(LEFT_DECO_COL);
        cand.row       = ROW_W'(SIDE_ROW0) + ROW_W'(cfg.pal_mode) + ROW_W'(side_idx[3:1]);
        cand.char_code = cfg.decoration_symbol;
      end else if (side_idx == SIDE_W'(SIDE_DECO_N)) begin
        cand.column    = COL_W'(LEFT_LEVEL_COL);
        cand.row       = ROW_W'(CENTER_ROW) + ROW_W'(cfg.pal_mode);
        cand.char_code = cfg.left_level_symbol;
      end else begin
        cand.column    = COL_W'(RIGHT_LEVEL_COL);
        cand.row       = ROW_W'(CENTER_ROW) + ROW_W'(cfg.pal_mode);
        cand.char_code = cfg.right_level_symbol;
      end
      cand.last = (step == STEP_W'(LAST_STEP));
    end
  end

  assign out_free = !out_valid || out_ready;
  assign done     = (step == STEP_W'(LAST_STEP)) ||
                    ((step == STEP_W'(NUM_LANES - 1)) && !cfg.sidebars_enable);
  assign advance  = busy && (out_free || !cand_ok);
  assign emit     = busy && cand_ok && out_free;
  assign in_ready = !busy || (advance && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        step <= '0;
      end else if (advance && done) begin
        busy <= 1'b0;
      end else if (advance) begin
        step <= step + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bars <= bars_in;
    end
    if (emit) begin
      res <= cand;
    end
  end

endmodule

// ===== rtl/artificial_horizon_char_placer.sv =====
// Artificial horizon character placer top level: config registers, ports, checks.
// Each write leaves through the item register and then the result register; bar columns
//   ahead of it without a write still take a step each, and m_tready stalls hold it back.
// Per attitude the step counter walks every bar column step, then the sidebar steps if on,
//   written or not; writes wait on m_tready. Next attitude is taken on the last step.
// Reset (rst, synchronous): sequencer idle, no pending output, registers to defaults.
module artificial_horizon_char_placer import ahcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // roll_angle[11:0], pitch_angle[22:12], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // column[4:0], row[9:5], char_code[17:10], zero pad
  output logic                 m_tlast
);

  cfg_t     cfg;
  bar_set_t bars_in;
  res_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pal_mode           <= 1'b0;
      cfg.sidebars_enable    <= 1'b1;
      cfg.bar_symbol_base    <= 8'd128;
      cfg.decoration_symbol  <= 8'd19;
      cfg.left_level_symbol  <= 8'd3;
      cfg.right_level_symbol <= 8'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAL_MODE:    cfg.pal_mode           <= cfg_data[0];
        REG_SIDEBARS:    cfg.sidebars_enable    <= cfg_data[0];
        REG_BAR_BASE:    cfg.bar_symbol_base    <= cfg_data;
        REG_DECO_SYM:    cfg.decoration_symbol  <= cfg_data;
        REG_LEFT_LEVEL:  cfg.left_level_symbol  <= cfg_data;
        REG_RIGHT_LEVEL: cfg.right_level_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  ahcp_front u_front (
    .roll_angle  (s_tdata[ROLL_W-1:0]),
    .pitch_angle (s_tdata[ROLL_W+PITCH_W-1:ROLL_W]),
    .bars        (bars_in)
  );

  ahcp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .bars_in   (bars_in),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {6'd0, res.char_code, res.row, res.column};
  assign m_tlast = res.last;

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] >= COL_W'(LEFT_DECO_COL)) &&
                 (m_tdata[4:0] <= COL_W'(RIGHT_DECO_COL)))
    else $error("column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:5] >= ROW_W'(BAR_ROW0)) && (m_tdata[9:5] <= ROW_W'(ROW_MAX)))
    else $error("row out of range");

endmodule
